// ===== hdl/tbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// tbcd_pkg
// shared types, constants and digit mapping for the tbcd digit codec
// ----------------------------------------------------------------------------
package tbcd_pkg;

    localparam int QUEUE_DEPTH = 3;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] HDR_OCTET  = 8'h91;
    localparam logic [3:0] PAD_NIBBLE = 4'hf;
    localparam logic [7:0] NUL_CHAR   = 8'h00;
    localparam logic [7:0] SENT_MAX   = 8'hff;

    // function codes
    localparam logic FUNC_DECODE = 1'b0;
    localparam logic FUNC_ENCODE = 1'b1;

    // register indexes
    localparam logic REG_MSISDN_MODE = 1'b0;
    localparam logic REG_OCTET_LIMIT = 1'b1;

    typedef struct packed {
        logic       msisdn_mode;
        logic [7:0] octet_limit;
    } tbcd_cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tbcd_res_t;

    // up to two results for one input word, in order
    typedef struct packed {
        logic [1:0] num;
        tbcd_res_t  res0;
        tbcd_res_t  res1;
    } tbcd_pair_t;

    function automatic logic [7:0] digit_char(input logic [3:0] nib);
        logic [7:0] c;
        case (nib)
            4'ha:    c = "*";
            4'hb:    c = "#";
            4'hc:    c = "a";
            4'hd:    c = "b";
            4'he:    c = "c";
            4'hf:    c = NUL_CHAR;
            default: c = 8'h30 + {4'h0, nib};
        endcase
        return c;
    endfunction

    function automatic logic [3:0] char_nibble(input logic [7:0] c);
        logic [7:0] d;
        logic [3:0] n;
        d = c - 8'h30;
        case (c)
            "*":     n = 4'ha;
            "#":     n = 4'hb;
            "a":     n = 4'hc;
            "b":     n = 4'hd;
            "c":     n = 4'he;
            default: n = d[3:0];
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/tbcd_digit_codec.sv =====
// ----------------------------------------------------------------------------
// tbcd_digit_codec
// swapped-nibble telephony bcd codec for called-party and msisdn numbers
// ----------------------------------------------------------------------------
// One input word is decoded or encoded in the cycle it is accepted and its
// results (zero, one or two) land in a three-entry result queue; with the
// queue empty, the first result is on the output the next cycle. The single
// result port gives one word a cycle while out_ready is high, so two-result
// words (decode, or the msisdn header with an octet) are paced by it, and
// words with at most one result run at one per cycle. in_ready is high while
// the queue has room for two results, so input is taken while a result waits.
// Configuration (msisdn_mode, octet_limit) is written through the cfg port,
// always ready, and is meant to change only between numbers.
module tbcd_digit_codec (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    // input word channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] data_in,
    input  logic       end_of_string,
    // result word channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_out,
    output logic       last_out
);

    tbcd_pkg::tbcd_cfg_t  cfg_reg;
    tbcd_pkg::tbcd_pair_t pair;
    logic                 accept;
    logic                 room;

    // config registers take a write every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.msisdn_mode <= 1'b0;
            cfg_reg.octet_limit <= 8'd8;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tbcd_pkg::REG_MSISDN_MODE: cfg_reg.msisdn_mode <= cfg_data[0];
                tbcd_pkg::REG_OCTET_LIMIT: cfg_reg.octet_limit <= cfg_data;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input is taken whenever two result slots are free
    assign in_ready = room;
    assign accept   = in_valid && in_ready;

    // number state and the per-word mapping
    tbcd_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .func          (func),
        .data_in       (data_in),
        .end_of_string (end_of_string),
        .cfg           (cfg_reg),
        .pair          (pair)
    );

    // results drain one a cycle while out_ready is high
    tbcd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .pair      (pair),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out),
        .last_out  (last_out)
    );

endmodule

// ===== hdl/tbcd_engine.sv =====
// ----------------------------------------------------------------------------
// tbcd_engine
// per-number state and single-pass decode / encode of one input word
// ----------------------------------------------------------------------------
module tbcd_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 func,
    input  logic [7:0]           data_in,
    input  logic                 end_of_string,
    input  tbcd_pkg::tbcd_cfg_t  cfg,
    output tbcd_pkg::tbcd_pair_t pair
);

    logic       at_start_reg,    at_start_next;
    logic [3:0] held_digit_reg,  held_digit_next;
    logic       digit_held_reg,  digit_held_next;
    logic [7:0] octets_sent_reg, octets_sent_next;
    logic       dropping_reg,    dropping_next;

    logic [3:0] nib;
    logic [7:0] sent_inc;
    logic       hdr;
    logic       oct_valid;
    logic [7:0] oct;
    logic       oct_last;
    logic       hit;

    assign nib      = tbcd_pkg::char_nibble(data_in);
    assign sent_inc = (octets_sent_reg == tbcd_pkg::SENT_MAX) ?
                      octets_sent_reg : octets_sent_reg + 8'd1;
    assign hit      = !cfg.msisdn_mode && (cfg.octet_limit != 8'd0) &&
                      (sent_inc >= cfg.octet_limit);

    always_comb
    begin
        pair             = '0;
        at_start_next    = at_start_reg;
        held_digit_next  = held_digit_reg;
        digit_held_next  = digit_held_reg;
        octets_sent_next = octets_sent_reg;
        dropping_next    = dropping_reg;
        hdr              = 1'b0;
        oct_valid        = 1'b0;
        oct              = '0;
        oct_last         = 1'b0;

        if (func == tbcd_pkg::FUNC_DECODE)
        begin
            at_start_next = 1'b0;
            if (cfg.msisdn_mode && at_start_reg)
            begin
                // leading header octet is swallowed
                pair.num  = end_of_string ? 2'd1 : 2'd0;
                pair.res0 = '{data: tbcd_pkg::NUL_CHAR, last: 1'b1};
            end
            else
            begin
                pair.num  = 2'd2;
                pair.res0 = '{data: tbcd_pkg::digit_char(data_in[3:0]), last: 1'b0};
                pair.res1 = '{data: tbcd_pkg::digit_char(data_in[7:4]),
                              last: end_of_string};
            end
        end
        else
        begin
            at_start_next = 1'b0;
            hdr           = at_start_reg && cfg.msisdn_mode;
            if (!dropping_reg)
            begin
                if (!digit_held_reg)
                begin
                    if (end_of_string)
                    begin
                        oct_valid        = 1'b1;
                        oct              = {tbcd_pkg::PAD_NIBBLE, nib};
                        oct_last         = 1'b1;
                        octets_sent_next = sent_inc;
                    end
                    else
                    begin
                        held_digit_next = nib;
                        digit_held_next = 1'b1;
                    end
                end
                else
                begin
                    oct_valid        = 1'b1;
                    oct              = {nib, held_digit_reg};
                    oct_last         = end_of_string || hit;
                    octets_sent_next = sent_inc;
                    held_digit_next  = '0;
                    digit_held_next  = 1'b0;
                    dropping_next    = hit && !end_of_string;
                end
            end
            if (hdr)
            begin
                pair.res0 = '{data: tbcd_pkg::HDR_OCTET, last: 1'b0};
                pair.res1 = '{data: oct, last: oct_last};
            end
            else
            begin
                pair.res0 = '{data: oct, last: oct_last};
            end
            pair.num = {1'b0, hdr} + {1'b0, oct_valid};
        end

        // end of a number clears all string state
        if (end_of_string)
        begin
            at_start_next    = 1'b1;
            held_digit_next  = '0;
            digit_held_next  = 1'b0;
            octets_sent_next = '0;
            dropping_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg    <= 1'b1;
            held_digit_reg  <= '0;
            digit_held_reg  <= 1'b0;
            octets_sent_reg <= '0;
            dropping_reg    <= 1'b0;
        end
        else if (accept)
        begin
            at_start_reg    <= at_start_next;
            held_digit_reg  <= held_digit_next;
            digit_held_reg  <= digit_held_next;
            octets_sent_reg <= octets_sent_next;
            dropping_reg    <= dropping_next;
        end
    end

    a_held_not_start: assert property (@(posedge clk) disable iff (!rst_n)
        digit_held_reg |-> !at_start_reg)
        else $error("digit held at start of number");

    a_drop_no_held: assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> (!digit_held_reg && !at_start_reg))
        else $error("dropping with held digit or at start");

    a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_string) |=> (at_start_reg && !dropping_reg && !digit_held_reg))
        else $error("end of number did not restart state");

endmodule

// ===== hdl/tbcd_outq.sv =====
// ----------------------------------------------------------------------------
// tbcd_outq
// small shifting result queue, takes up to two results, gives one a cycle while out_ready is high
// ----------------------------------------------------------------------------
module tbcd_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tbcd_pkg::tbcd_pair_t pair,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           data_out,
    output logic                 last_out
);

    localparam int D = tbcd_pkg::QUEUE_DEPTH;
    localparam int W = tbcd_pkg::CNT_W;

    logic [W-1:0]        count_reg, count_next;
    tbcd_pkg::tbcd_res_t entry_reg  [D];
    tbcd_pkg::tbcd_res_t entry_next [D];

    logic         pop;
    logic [W-1:0] base;
    logic [W-1:0] push_num;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= W'(D - 2));
    assign base      = count_reg - W'(pop);
    assign push_num  = push ? W'(pair.num) : '0;
    assign count_next = base + push_num;
    assign data_out  = entry_reg[0].data;
    assign last_out  = entry_reg[0].last;

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            entry_next[i] = entry_reg[i];
            if (pop && (i < D - 1))
            begin
                entry_next[i] = entry_reg[i + 1];
            end
            if ((push_num != '0) && (i == int'(base)))
            begin
                entry_next[i] = pair.res0;
            end
            if ((push_num == W'(2)) && (i == int'(base) + 1))
            begin
                entry_next[i] = pair.res1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < D; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
    end

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (int'(count_reg) + int'(pair.num) <= D))
        else $error("result queue overflow");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == W'($past(count_reg) - W'(1))))
        else $error("result queue count wrong after pop");

endmodule
